// ----- src/bmhpq_pkg.sv -----
`default_nettype none

package bmhpq_pkg;

  localparam int PrioW = 32;
  localparam int PayW  = 32;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_ROOT,
    S_POP_LAST,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMPR,
    S_PLACE,
    S_RESP
  } state_e;

  typedef enum logic [2:0] {
    RA_ZERO,
    RA_LAST,
    RA_PARENT,
    RA_LEFT,
    RA_RIGHT
  } rd_sel_e;

  typedef enum logic [1:0] {
    WS_CUR,
    WS_RD,
    WS_LEFT
  } wr_sel_e;

  typedef enum logic [2:0] {
    PS_KEEP,
    PS_CNT,
    PS_ZERO,
    PS_PARENT,
    PS_LEFT,
    PS_RIGHT
  } pos_sel_e;

  typedef enum logic [1:0] {
    CS_UP,
    CS_DNL,
    CS_DNR
  } cmp_sel_e;

  typedef struct packed {
    logic signed [PrioW-1:0] prio;
    logic signed [PayW-1:0]  pay;
  } entry_t;

  typedef struct packed {
    logic in_valid;
    logic in_pop;
    logic full;
    logic empty;
    logic par_zero;
    logic l_ok;
    logic r_ok;
    logic lt;
    logic lgt;
    logic out_free;
  } flags_t;

  typedef struct packed {
    logic     ready;
    logic     take;
    status_e  status;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     wr_en;
    wr_sel_e  wr_sel;
    pos_sel_e pos_sel;
    cmp_sel_e cmp_sel;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     ld_root;
    logic     ld_cur;
    logic     ld_left;
    logic     emit;
  } ctrl_t;

endpackage

`default_nettype wire

// ----- src/binary_max_heap_priority_queue.sv -----
// Max-priority queue held as a binary heap of (priority, payload) entries.
// Input channel s_axis: tuser carries the op (0 push, 1 pop); tdata carries
// priority_req and payload. Output channel m_axis: one result item per input
// item; tuser carries status (0 done, 1 push dropped as full, 2 pop on empty),
// tdata carries out_payload, out_priority and occupancy.
// An item is handled by a small sequencer around one signed comparator and a
// single-port heap RAM (one read or one write per cycle, registered read).
// Push: each parent compare (C of them, at most log2(CAPACITY), 0 when the
// queue was empty) reads the parent first; the entry is then placed.
// Pop: reads the root, then the last entry, then descends L levels, each
// reading the left and then the right child; a step down to a lone left child
// skips the right-child read, and popping the only entry skips the descent.
// A full push or an empty pop goes straight to the result. s_axis_tready_o is
// high only between items, so an item is taken only once the last is done.
// The result sits in an output register; the next item is accepted while it
// waits, but its own result is held back until m_axis_tready_i takes the
// previous one. Reset empties the queue; RAM contents need no clearing.
`default_nettype none

module binary_max_heap_priority_queue #(
  parameter int CAPACITY = 64,
  localparam int CntW = $clog2(CAPACITY + 1),
  localparam int OutW = ((64 + CntW + 7) / 8) * 8
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire  [63:0]     s_axis_tdata_i,   // priority_req, payload
  input  wire  [0:0]      s_axis_tuser_i,   // op
  output logic            m_axis_tvalid_o,
  input  wire             m_axis_tready_i,
  output logic [OutW-1:0] m_axis_tdata_o,   // out_payload, out_priority, occupancy
  output logic [1:0]      m_axis_tuser_o    // status
);
  import bmhpq_pkg::*;

  localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int ExtW  = AddrW + 2;

  flags_t flags;
  ctrl_t  ctrl;

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic             lgt_q;
  entry_t           cur_q, left_q, rd_q;
  status_e          res_status_q;
  logic [PayW-1:0]  res_pay_q;
  logic [PrioW-1:0] res_prio_q;

  logic             m_valid_q, m_valid_d;
  status_e          m_status_q;
  logic [PayW-1:0]  m_pay_q;
  logic [PrioW-1:0] m_prio_q;
  logic [CntW-1:0]  m_occ_q;

  entry_t mem_q [CAPACITY];

  logic [AddrW-1:0] parent_idx, rd_addr;
  logic [ExtW-1:0]  left_ext, right_ext, cnt_ext;
  entry_t           wr_data;
  logic signed [PrioW-1:0] cmp_a, cmp_b;
  logic             cmp_lt;

  assign parent_idx = AddrW'((pos_q - AddrW'(1)) >> 1);
  assign left_ext   = ExtW'({pos_q, 1'b1});
  assign right_ext  = left_ext + ExtW'(1);
  assign cnt_ext    = ExtW'(cnt_q);

  // shared compare unit
  always_comb begin
    cmp_a = cur_q.prio;
    cmp_b = rd_q.prio;
    case (ctrl.cmp_sel)
      CS_UP: begin
        cmp_a = rd_q.prio;
        cmp_b = cur_q.prio;
      end
      CS_DNL: cmp_a = cur_q.prio;
      CS_DNR: cmp_a = lgt_q ? left_q.prio : cur_q.prio;
      default: ;
    endcase
  end
  assign cmp_lt = cmp_a < cmp_b;

  always_comb begin
    flags          = '0;
    flags.in_valid = s_axis_tvalid_i;
    flags.in_pop   = (s_axis_tuser_i[0] == OP_POP);
    flags.full     = (cnt_q == CntW'(CAPACITY));
    flags.empty    = (cnt_q == '0);
    flags.par_zero = (parent_idx == '0);
    flags.l_ok     = (left_ext < cnt_ext);
    flags.r_ok     = (right_ext < cnt_ext);
    flags.lt       = cmp_lt;
    flags.lgt      = lgt_q;
    flags.out_free = !m_valid_q || m_axis_tready_i;
  end

  bmhpq_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  always_comb begin
    unique case (ctrl.rd_sel)
      RA_ZERO:   rd_addr = '0;
      RA_LAST:   rd_addr = cnt_q[AddrW-1:0];
      RA_PARENT: rd_addr = parent_idx;
      RA_LEFT:   rd_addr = left_ext[AddrW-1:0];
      RA_RIGHT:  rd_addr = right_ext[AddrW-1:0];
      default:   rd_addr = '0;
    endcase
  end

  always_comb begin
    unique case (ctrl.wr_sel)
      WS_CUR:  wr_data = cur_q;
      WS_RD:   wr_data = rd_q;
      WS_LEFT: wr_data = left_q;
      default: wr_data = cur_q;
    endcase
  end

  always_comb begin
    unique case (ctrl.pos_sel)
      PS_KEEP:   pos_d = pos_q;
      PS_CNT:    pos_d = cnt_q[AddrW-1:0];
      PS_ZERO:   pos_d = '0;
      PS_PARENT: pos_d = parent_idx;
      PS_LEFT:   pos_d = left_ext[AddrW-1:0];
      PS_RIGHT:  pos_d = right_ext[AddrW-1:0];
      default:   pos_d = pos_q;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.cnt_inc) cnt_d = cnt_q + CntW'(1);
    else if (ctrl.cnt_dec) cnt_d = cnt_q - CntW'(1);
  end

  assign m_valid_d = ctrl.emit || (m_valid_q && !m_axis_tready_i);

  // heap RAM
  always_ff @(posedge clk_i) begin
    if (ctrl.wr_en) mem_q[pos_q] <= wr_data;
    if (ctrl.rd_en) rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (ctrl.take) begin
      cur_q.prio   <= s_axis_tdata_i[31:0];
      cur_q.pay    <= s_axis_tdata_i[63:32];
      res_status_q <= ctrl.status;
      res_pay_q    <= '0;
      res_prio_q   <= '0;
    end
    if (ctrl.ld_root) begin
      res_pay_q  <= rd_q.pay;
      res_prio_q <= rd_q.prio;
    end
    if (ctrl.ld_cur) cur_q <= rd_q;
    if (ctrl.ld_left) begin
      left_q <= rd_q;
      lgt_q  <= cmp_lt;
    end
    if (ctrl.emit) begin
      m_status_q <= res_status_q;
      m_pay_q    <= res_pay_q;
      m_prio_q   <= res_prio_q;
      m_occ_q    <= cnt_q;
    end
  end

  assign s_axis_tready_o = ctrl.ready;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OutW'({m_occ_q, m_prio_q, m_pay_q});
  assign m_axis_tuser_o  = m_status_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("second item taken while one is in work");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_status_q == ST_EMPTY) |-> (m_occ_q == '0))
    else $error("empty pop reports nonzero occupancy");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_status_q == ST_FULL) |-> (m_occ_q == CntW'(CAPACITY)))
    else $error("dropped push reports occupancy below capacity");

endmodule

`default_nettype wire

// ----- src/bmhpq_seq.sv -----
`default_nettype none

module bmhpq_seq (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  bmhpq_pkg::flags_t  flags_i,
  output bmhpq_pkg::ctrl_t   ctrl_o
);
  import bmhpq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (flags_i.in_valid) begin
          if (!flags_i.in_pop) begin
            if (flags_i.full) state_d = S_RESP;
            else if (flags_i.empty) state_d = S_PLACE;
            else state_d = S_UP_RD;
          end else begin
            if (flags_i.empty) state_d = S_RESP;
            else state_d = S_POP_ROOT;
          end
        end
      end
      S_UP_RD:  state_d = S_UP_CMP;
      S_UP_CMP: begin
        if (flags_i.lt && !flags_i.par_zero) state_d = S_UP_RD;
        else state_d = S_PLACE;
      end
      S_POP_ROOT: begin
        if (flags_i.empty) state_d = S_RESP;
        else state_d = S_POP_LAST;
      end
      S_POP_LAST: state_d = S_DN_RDL;
      S_DN_RDL: begin
        if (flags_i.l_ok) state_d = S_DN_RDR;
        else state_d = S_PLACE;
      end
      S_DN_RDR: begin
        if (flags_i.r_ok) state_d = S_DN_CMPR;
        else if (flags_i.lt) state_d = S_DN_RDL;
        else state_d = S_PLACE;
      end
      S_DN_CMPR: begin
        if (flags_i.lt || flags_i.lgt) state_d = S_DN_RDL;
        else state_d = S_PLACE;
      end
      S_PLACE: state_d = S_RESP;
      S_RESP: begin
        if (flags_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.status  = ST_DONE;
    ctrl_o.rd_sel  = RA_ZERO;
    ctrl_o.wr_sel  = WS_CUR;
    ctrl_o.pos_sel = PS_KEEP;
    ctrl_o.cmp_sel = CS_UP;
    unique case (state_q)
      S_IDLE: begin
        ctrl_o.ready = 1'b1;
        if (flags_i.in_valid) begin
          ctrl_o.take = 1'b1;
          if (!flags_i.in_pop) begin
            if (flags_i.full) begin
              ctrl_o.status = ST_FULL;
            end else begin
              ctrl_o.cnt_inc = 1'b1;
              ctrl_o.pos_sel = PS_CNT;
            end
          end else begin
            if (flags_i.empty) begin
              ctrl_o.status = ST_EMPTY;
            end else begin
              ctrl_o.rd_en   = 1'b1;
              ctrl_o.rd_sel  = RA_ZERO;
              ctrl_o.cnt_dec = 1'b1;
            end
          end
        end
      end
      S_UP_RD: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_sel = RA_PARENT;
      end
      S_UP_CMP: begin
        ctrl_o.cmp_sel = CS_UP;
        if (flags_i.lt) begin
          ctrl_o.wr_en   = 1'b1;
          ctrl_o.wr_sel  = WS_RD;
          ctrl_o.pos_sel = PS_PARENT;
        end
      end
      S_POP_ROOT: begin
        ctrl_o.ld_root = 1'b1;
        if (!flags_i.empty) begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = RA_LAST;
        end
      end
      S_POP_LAST: begin
        ctrl_o.ld_cur  = 1'b1;
        ctrl_o.pos_sel = PS_ZERO;
      end
      S_DN_RDL: begin
        if (flags_i.l_ok) begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = RA_LEFT;
        end
      end
      S_DN_RDR: begin
        ctrl_o.cmp_sel = CS_DNL;
        ctrl_o.ld_left = 1'b1;
        if (flags_i.r_ok) begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = RA_RIGHT;
        end else if (flags_i.lt) begin
          ctrl_o.wr_en   = 1'b1;
          ctrl_o.wr_sel  = WS_RD;
          ctrl_o.pos_sel = PS_LEFT;
        end
      end
      S_DN_CMPR: begin
        ctrl_o.cmp_sel = CS_DNR;
        if (flags_i.lt) begin
          ctrl_o.wr_en   = 1'b1;
          ctrl_o.wr_sel  = WS_RD;
          ctrl_o.pos_sel = PS_RIGHT;
        end else if (flags_i.lgt) begin
          ctrl_o.wr_en   = 1'b1;
          ctrl_o.wr_sel  = WS_LEFT;
          ctrl_o.pos_sel = PS_LEFT;
        end
      end
      S_PLACE: begin
        ctrl_o.wr_en  = 1'b1;
        ctrl_o.wr_sel = WS_CUR;
      end
      S_RESP: begin
        ctrl_o.emit = flags_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- verif/bmhpq_checker.sv -----
module bmhpq_checker #(
  parameter int CAPACITY = 64,
  parameter int OutW     = 72
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            s_axis_tvalid_i,
  input  wire            s_axis_tready_i,
  input  wire [63:0]     s_axis_tdata_i,
  input  wire [0:0]      s_axis_tuser_i,
  input  wire            m_axis_tvalid_i,
  input  wire            m_axis_tready_i,
  input  wire [OutW-1:0] m_axis_tdata_i,
  input  wire [1:0]      m_axis_tuser_i,
  output int             err_cnt_o,
  output int             pending_o
);
  import bmhpq_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);

  typedef struct packed {
    status_e             status;
    logic [PayW-1:0]     pay;
    logic [PrioW-1:0]    prio;
    logic [CntW-1:0]     occ;
  } heap_result_t;

  entry_t       heap_mem [CAPACITY];
  int           held;
  heap_result_t pending_results[$];
  heap_result_t want;
  int           err_cnt;

  assign err_cnt_o = err_cnt;

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    err_cnt++;
    $display("mismatch on %s: got %0h, want %0h (t=%0t)", field, got, exp_val, $time);
  endtask

  function automatic void swap_slots(input int a, input int b);
    entry_t tmp;
    tmp         = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = tmp;
  endfunction

  function automatic heap_result_t predict_heap_op(input logic op,
                                                   input logic signed [PrioW-1:0] prio,
                                                   input logic signed [PayW-1:0] pay);
    heap_result_t res;
    int           pos;
    int           par;
    int           lc;
    int           rc;
    int           nxt;
    bit           walking;
    res        = '0;
    res.status = ST_DONE;
    if (op == OP_PUSH) begin
      if (held >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        heap_mem[held].prio = prio;
        heap_mem[held].pay  = pay;
        pos     = held;
        held++;
        walking = 1'b1;
        while (walking && pos > 0) begin
          par = (pos - 1) / 2;
          if (heap_mem[par].prio < heap_mem[pos].prio) begin
            swap_slots(par, pos);
            pos = par;
          end else begin
            walking = 1'b0;
          end
        end
      end
    end else begin
      if (held == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.pay     = heap_mem[0].pay;
        res.prio    = heap_mem[0].prio;
        held--;
        heap_mem[0] = heap_mem[held];
        pos     = 0;
        walking = 1'b1;
        while (walking) begin
          lc  = 2 * pos + 1;
          rc  = lc + 1;
          nxt = pos;
          if (rc < held && heap_mem[lc].prio < heap_mem[rc].prio &&
              heap_mem[pos].prio < heap_mem[rc].prio) begin
            nxt = rc;
          end else if (lc < held && heap_mem[pos].prio < heap_mem[lc].prio) begin
            nxt = lc;
          end else begin
            walking = 1'b0;
          end
          if (walking) begin
            swap_slots(pos, nxt);
            pos = nxt;
          end
        end
      end
    end
    res.occ = held[CntW-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held = 0;
      pending_results.delete();
      pending_o = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        pending_results = {pending_results,
                           predict_heap_op(s_axis_tuser_i[0], s_axis_tdata_i[31:0],
                                           s_axis_tdata_i[63:32])};
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata_i[63:0], '0);
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tuser_i != want.status)
            report_mismatch("status", 64'(m_axis_tuser_i), 64'(want.status));
          if (m_axis_tdata_i[31:0] != want.pay)
            report_mismatch("out_payload", 64'(m_axis_tdata_i[31:0]), 64'(want.pay));
          if (m_axis_tdata_i[63:32] != want.prio)
            report_mismatch("out_priority", 64'(m_axis_tdata_i[63:32]), 64'(want.prio));
          if (m_axis_tdata_i[64 +: CntW] != want.occ)
            report_mismatch("occupancy", 64'(m_axis_tdata_i[64 +: CntW]), 64'(want.occ));
        end
      end
      pending_o = pending_results.size();
    end
  end

endmodule

// ----- verif/binary_max_heap_priority_queue_tb.sv -----
module binary_max_heap_priority_queue_tb;
  import bmhpq_pkg::*;

  localparam int CAPACITY   = 64;
  localparam int CntW       = $clog2(CAPACITY + 1);
  localparam int OutW       = ((64 + CntW + 7) / 8) * 8;
  localparam int CycleLimit = 1_000_000;
  localparam int HoldCycles = 400;

  typedef enum int {
    RUN_FILL,
    RUN_DRAIN,
    RUN_MIX
  } run_kind_e;

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid_i;
  logic            s_axis_tready_o;
  logic [63:0]     s_axis_tdata_i;   // priority_req, payload
  logic [0:0]      s_axis_tuser_i;   // op
  logic            m_axis_tvalid_o;
  logic            m_axis_tready_i;
  logic [OutW-1:0] m_axis_tdata_o;   // out_payload, out_priority, occupancy
  logic [1:0]      m_axis_tuser_o;   // status

  int err_cnt;
  int pending;
  int cycle_cnt;
  int snd_idle_pct;
  int rcv_idle_pct;
  int occ_guess;
  bit hold_rx;
  bit start_hold;

  binary_max_heap_priority_queue #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  bmhpq_checker #(
    .CAPACITY(CAPACITY),
    .OutW    (OutW)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o),
    .m_axis_tuser_i (m_axis_tuser_o),
    .err_cnt_o      (err_cnt),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= !hold_rx && ($urandom_range(99) >= rcv_idle_pct);
  end

  // long receiver stall so the output register fills and the input backs up
  initial begin
    wait (start_hold);
    @(posedge clk_i);
    hold_rx = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  task automatic send_item(input logic op, input logic [31:0] prio, input logic [31:0] pay);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = op;
    s_axis_tdata_i  = {pay, prio};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (op == OP_PUSH) begin
      if (occ_guess < CAPACITY) occ_guess++;
    end else if (occ_guess > 0) begin
      occ_guess--;
    end
  endtask

  function automatic logic [31:0] pick_priority();
    int unsigned sel;
    logic [31:0] mag;
    sel = $urandom_range(99);
    if (sel < 40) return $urandom();
    if (sel < 75) return 32'($urandom_range(8)) - 32'd4;
    if (sel < 85) begin
      case ($urandom_range(3))
        0:       return 32'h7fff_ffff;
        1:       return 32'h8000_0000;
        2:       return 32'h0;
        default: return 32'hffff_ffff;
      endcase
    end
    mag = 32'($urandom_range(1000));
    return $urandom_range(1) ? -mag : mag;
  endfunction

  task automatic run_random(input int n_items);
    int        sent;
    int        run_left;
    int        full_hits;
    int        empty_hits;
    int        push_pct;
    logic      op;
    run_kind_e kind;
    sent       = 0;
    run_left   = 0;
    full_hits  = 0;
    empty_hits = 0;
    kind       = RUN_FILL;
    while (sent < n_items) begin
      case (kind)
        RUN_FILL:  push_pct = 85;
        RUN_DRAIN: push_pct = 15;
        default:   push_pct = 50;
      endcase
      op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
      if (op == OP_PUSH && occ_guess == CAPACITY) full_hits++;
      if (op == OP_POP && occ_guess == 0) empty_hits++;
      send_item(op, pick_priority(), $urandom());
      sent++;
      run_left--;
      if ((kind == RUN_FILL && full_hits >= 2) || (kind == RUN_DRAIN && empty_hits >= 2) ||
          (kind == RUN_MIX && run_left <= 0)) begin
        kind       = run_kind_e'($urandom_range(2));
        run_left   = $urandom_range(20, 80);
        full_hits  = 0;
        empty_hits = 0;
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_PUSH;
    start_hold      = 1'b0;
    occ_guess       = 0;
    snd_idle_pct    = 31;
    rcv_idle_pct    = 60;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty pop, extremes, ties, then drain past empty
    send_item(OP_POP, $urandom(), $urandom());
    send_item(OP_PUSH, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(OP_PUSH, 32'h8000_0000, 32'h8000_0000);
    send_item(OP_PUSH, 32'h0, 32'h0);
    send_item(OP_PUSH, 32'hffff_ffff, 32'hffff_ffff);
    send_item(OP_PUSH, 32'd5, 32'd1);
    send_item(OP_PUSH, 32'd5, 32'd2);
    send_item(OP_PUSH, 32'd5, 32'd3);
    send_item(OP_PUSH, 32'd7, 32'd4);
    send_item(OP_PUSH, 32'd5, 32'd5);
    repeat (10) send_item(OP_POP, $urandom(), $urandom());

    run_random(600);

    snd_idle_pct = 60;
    rcv_idle_pct = 31;
    run_random(600);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    start_hold   = 1'b1;
    run_random(600);

    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
